// ===== sv/spc_pkg.sv =====
// Shared types, codes and helper functions of the servo pair slew controller.
// Used by every module of the block; depends on nothing else.

package spc_pkg;

	localparam int ANG_W   = 18;
	localparam int ORG_W   = 19;
	localparam int CMD_W   = 20;
	localparam int SPEED_W = 10;
	localparam int EL_W    = 18;
	localparam int STEP_W  = EL_W + SPEED_W;
	localparam int SPAN_W  = STEP_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QCNT_W      = QUEUE_AW + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd5;

	localparam logic [3:0] REQ_TICK        = 4'd0;
	localparam logic [3:0] REQ_SET_TARGET  = 4'd1;
	localparam logic [3:0] REQ_ENABLE      = 4'd2;
	localparam logic [3:0] REQ_DISABLE     = 4'd3;
	localparam logic [3:0] REQ_SINGLE      = 4'd4;
	localparam logic [3:0] REQ_TANDEM      = 4'd5;
	localparam logic [3:0] REQ_INDEPENDENT = 4'd6;
	localparam logic [3:0] REQ_ORIGIN_HERE = 4'd7;
	localparam logic [3:0] REQ_LOAD_ORIGIN = 4'd8;

	localparam logic [1:0] JSEL_A = 2'd0;
	localparam logic [1:0] JSEL_B = 2'd1;

	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_A     = 3'd1;
	localparam logic [2:0] MODE_B     = 3'd2;
	localparam logic [2:0] MODE_PAIR  = 3'd3;
	localparam logic [2:0] MODE_INDEP = 3'd4;

	localparam logic signed [CMD_W-1:0] MAN_LIM = 20'sd90000;
	localparam logic signed [CMD_W-1:0] CMD_LIM = 20'sd270000;
	localparam logic signed [CMD_W-1:0] ORG_LIM = 20'sd180000;

	typedef enum logic [3:0] {
		KIND_TICK        = 4'd0,
		KIND_TARGET      = 4'd1,
		KIND_ENABLE      = 4'd2,
		KIND_DISABLE     = 4'd3,
		KIND_SINGLE_A    = 4'd4,
		KIND_SINGLE_B    = 4'd5,
		KIND_DISARM      = 4'd6,
		KIND_TANDEM      = 4'd7,
		KIND_INDEP       = 4'd8,
		KIND_ORIGIN_HERE = 4'd9,
		KIND_ORIGIN_LOAD = 4'd10,
		KIND_NOP         = 4'd11
	} kind_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] pitch_min;
		logic signed [ANG_W-1:0] pitch_max;
		logic signed [ANG_W-1:0] yaw_min;
		logic signed [ANG_W-1:0] yaw_max;
		logic [SPEED_W-1:0]      max_speed;
		logic [SPEED_W-1:0]      period;
	} cfg_t;

	typedef struct packed {
		kind_t                   kind;
		logic [31:0]             now_ms;
		logic signed [ANG_W-1:0] tgt_p;
		logic signed [ANG_W-1:0] tgt_y;
		logic signed [ANG_W-1:0] man_a;
		logic signed [ANG_W-1:0] man_b;
		logic signed [ORG_W-1:0] org_a;
		logic signed [ORG_W-1:0] org_b;
	} qent_t;

	typedef struct packed {
		logic                    wa_valid;
		logic signed [CMD_W-1:0] wa_angle;
		logic                    wb_valid;
		logic signed [CMD_W-1:0] wb_angle;
		logic                    a_att;
		logic                    b_att;
		logic                    armed;
		logic [2:0]              mode;
		logic signed [CMD_W-1:0] last_a;
		logic signed [CMD_W-1:0] last_b;
		logic signed [ORG_W-1:0] org_a;
		logic signed [ORG_W-1:0] org_b;
	} res_t;

	function automatic logic signed [CMD_W-1:0] clamp20(
		input logic signed [CMD_W-1:0] x,
		input logic signed [CMD_W-1:0] lo,
		input logic signed [CMD_W-1:0] hi
	);
		logic signed [CMD_W-1:0] r;
		if (x < lo) begin
			r = lo;
		end else if (x > hi) begin
			r = hi;
		end else begin
			r = x;
		end
		return r;
	endfunction

	// Moves cur toward tgt by at most step; the result always lies between the two.
	function automatic logic signed [ANG_W-1:0] approach(
		input logic signed [ANG_W-1:0] cur,
		input logic signed [ANG_W-1:0] tgt,
		input logic [STEP_W-1:0]       step
	);
		logic signed [SPAN_W-1:0] d;
		logic signed [SPAN_W-1:0] st;
		logic signed [SPAN_W-1:0] up;
		logic signed [SPAN_W-1:0] dn;
		logic signed [ANG_W-1:0]  r;
		d  = SPAN_W'(tgt) - SPAN_W'(cur);
		st = $signed({1'b0, step});
		up = SPAN_W'(cur) + st;
		dn = SPAN_W'(cur) - st;
		if (d > st) begin
			r = up[ANG_W-1:0];
		end else if (d < -st) begin
			r = dn[ANG_W-1:0];
		end else begin
			r = tgt;
		end
		return r;
	endfunction

endpackage

// ===== sv/servo_pair_slew_controller.sv =====
// Servo pair slew controller, top level.
// A request accepted into the queue passes through the scheduling stage, then the execution
// stage into the output register. Throughput: one request per cycle unless m_tready stalls
// the output; the four-entry queue decouples input from output.
// Reset clears all motion, origin and attachment state and loads the default limits,
// speed and update period; no clearing pass is needed.

module servo_pair_slew_controller import spc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [71:0]           s_tdata,   // now_ms, value_a, value_b
	input  logic [5:0]            s_tuser,   // req_type, joint_sel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [127:0]          m_tdata,   // write_a_angle, write_b_angle, a_attached,
	                                         // b_attached, motion_enabled, drive_mode, last_a,
	                                         // last_b, origin_a_out, origin_b_out, zero pad
	output logic [1:0]            m_tuser,   // write_a_valid, write_b_valid
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	qent_t front_ent;
	qent_t queue_ent;
	logic  queue_valid;
	logic  back_ready;
	res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pitch_min <= -18'sd45000;
			cfg_q.pitch_max <= 18'sd45000;
			cfg_q.yaw_min   <= -18'sd45000;
			cfg_q.yaw_max   <= 18'sd45000;
			cfg_q.max_speed <= 10'd90;
			cfg_q.period    <= 10'd20;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PITCH_MIN: cfg_q.pitch_min <= $signed(cfg_data);
				CFG_PITCH_MAX: cfg_q.pitch_max <= $signed(cfg_data);
				CFG_YAW_MIN:   cfg_q.yaw_min   <= $signed(cfg_data);
				CFG_YAW_MAX:   cfg_q.yaw_max   <= $signed(cfg_data);
				CFG_SPEED:     cfg_q.max_speed <= cfg_data[SPEED_W-1:0];
				CFG_PERIOD:    cfg_q.period    <= cfg_data[SPEED_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	spc_front u_front (
		.req_type  (s_tuser[3:0]),
		.joint_sel (s_tuser[5:4]),
		.now_ms    (s_tdata[31:0]),
		.value_a   ($signed(s_tdata[51:32])),
		.value_b   ($signed(s_tdata[71:52])),
		.cfg       (cfg_q),
		.ent       (front_ent)
	);

	spc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_tvalid),
		.push_ready (s_tready),
		.push_data  (front_ent),
		.pop_valid  (queue_valid),
		.pop_ready  (back_ready),
		.pop_data   (queue_ent)
	);

	spc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (queue_valid),
		.in_ready  (back_ready),
		.in_ent    (queue_ent),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = {res.wb_valid, res.wa_valid};
	assign m_tdata = {4'd0, res.org_b, res.org_a, res.last_b, res.last_a, res.mode,
		res.armed, res.b_att, res.a_att, res.wb_angle, res.wa_angle};

endmodule

// ===== sv/spc_front.sv =====
// Front end: classifies an incoming request and applies the clamps that depend
// only on the request and the configuration. Depends on spc_pkg.

module spc_front import spc_pkg::*; (
	input  logic [3:0]              req_type,
	input  logic [1:0]              joint_sel,
	input  logic [31:0]             now_ms,
	input  logic signed [CMD_W-1:0] value_a,
	input  logic signed [CMD_W-1:0] value_b,
	input  cfg_t                    cfg,
	output qent_t                   ent
);

	logic signed [CMD_W-1:0] tgt_p_c;
	logic signed [CMD_W-1:0] tgt_y_c;
	logic signed [CMD_W-1:0] man_a_c;
	logic signed [CMD_W-1:0] man_b_c;
	logic signed [CMD_W-1:0] org_a_c;
	logic signed [CMD_W-1:0] org_b_c;

	always_comb begin
		tgt_p_c = clamp20(value_a, CMD_W'(cfg.pitch_min), CMD_W'(cfg.pitch_max));
		tgt_y_c = clamp20(value_b, CMD_W'(cfg.yaw_min), CMD_W'(cfg.yaw_max));
		man_a_c = clamp20(value_a, -MAN_LIM, MAN_LIM);
		man_b_c = clamp20(value_b, -MAN_LIM, MAN_LIM);
		org_a_c = clamp20(value_a, -ORG_LIM, ORG_LIM);
		org_b_c = clamp20(value_b, -ORG_LIM, ORG_LIM);
	end

	always_comb begin
		ent.now_ms = now_ms;
		ent.tgt_p  = tgt_p_c[ANG_W-1:0];
		ent.tgt_y  = tgt_y_c[ANG_W-1:0];
		ent.man_a  = man_a_c[ANG_W-1:0];
		ent.man_b  = man_b_c[ANG_W-1:0];
		ent.org_a  = org_a_c[ORG_W-1:0];
		ent.org_b  = org_b_c[ORG_W-1:0];
		case (req_type)
			REQ_TICK:        ent.kind = KIND_TICK;
			REQ_SET_TARGET:  ent.kind = KIND_TARGET;
			REQ_ENABLE:      ent.kind = KIND_ENABLE;
			REQ_DISABLE:     ent.kind = KIND_DISABLE;
			REQ_SINGLE: begin
				case (joint_sel)
					JSEL_A:  ent.kind = KIND_SINGLE_A;
					JSEL_B:  ent.kind = KIND_SINGLE_B;
					default: ent.kind = KIND_DISARM;
				endcase
			end
			REQ_TANDEM:      ent.kind = KIND_TANDEM;
			REQ_INDEPENDENT: ent.kind = KIND_INDEP;
			REQ_ORIGIN_HERE: ent.kind = KIND_ORIGIN_HERE;
			REQ_LOAD_ORIGIN: ent.kind = KIND_ORIGIN_LOAD;
			default:         ent.kind = KIND_NOP;
		endcase
	end

endmodule

// ===== sv/spc_queue.sv =====
// Short queue of classified requests between the front end and the back end.
// Depends on spc_pkg for the entry type and the depth.

module spc_queue import spc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  qent_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_data
);

	localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

	qent_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QUEUE_FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_FULL)
		else $error("queue fill count exceeds its depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("queue fill count did not drop after a pop");

endmodule

// ===== sv/spc_back.sv =====
// Back end: a scheduling stage that owns arming and tick timing, then an
// execution stage that owns positions, origins and attachment and fills the
// output register. Depends on spc_pkg.

module spc_back import spc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  qent_t in_ent,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	logic adv;

	// Scheduling stage state and pipeline registers.
	logic               armed_q;
	logic [31:0]        last_tick_q;
	logic               valid_s1;
	qent_t              ent_s1;
	logic               fire_s1;
	logic               copy_s1;
	logic               armed_s1;
	logic [STEP_W-1:0]  step_s1;

	logic [31:0]        el;
	logic [EL_W-1:0]    el_sat;
	logic               fire_d;
	logic               copy_d;
	logic               armed_d;

	// Execution stage state.
	logic signed [ANG_W-1:0] cur_p_q;
	logic signed [ANG_W-1:0] cur_y_q;
	logic signed [ANG_W-1:0] tgt_p_q;
	logic signed [ANG_W-1:0] tgt_y_q;
	logic signed [ORG_W-1:0] org_a_q;
	logic signed [ORG_W-1:0] org_b_q;
	logic signed [CMD_W-1:0] man_a_q;
	logic signed [CMD_W-1:0] man_b_q;
	logic [2:0]              mode_q;
	logic                    att_a_q;
	logic                    att_b_q;
	logic                    out_valid_q;
	res_t                    out_q;

	logic signed [ANG_W-1:0] cur_p_d;
	logic signed [ANG_W-1:0] cur_y_d;
	logic signed [ANG_W-1:0] tgt_p_d;
	logic signed [ANG_W-1:0] tgt_y_d;
	logic signed [ORG_W-1:0] org_a_d;
	logic signed [ORG_W-1:0] org_b_d;
	logic signed [CMD_W-1:0] man_a_d;
	logic signed [CMD_W-1:0] man_b_d;
	logic [2:0]              mode_d;
	logic                    att_a_d;
	logic                    att_b_d;
	res_t                    res_d;

	logic signed [ANG_W-1:0] slew_p;
	logic signed [ANG_W-1:0] slew_y;
	logic signed [CMD_W-1:0] tick_a;
	logic signed [CMD_W-1:0] tick_b;
	logic signed [CMD_W-1:0] pair_a;
	logic signed [CMD_W-1:0] pair_b;
	logic signed [CMD_W-1:0] here_a;
	logic signed [CMD_W-1:0] here_b;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_comb begin
		el      = in_ent.now_ms - last_tick_q;
		el_sat  = (|el[31:EL_W]) ? '1 : el[EL_W-1:0];
		fire_d  = 1'b0;
		copy_d  = 1'b0;
		armed_d = armed_q;
		case (in_ent.kind)
			KIND_TICK: fire_d = armed_q && (el >= 32'(cfg.period));
			KIND_TARGET: begin
				copy_d  = !armed_q;
				armed_d = 1'b1;
			end
			KIND_ENABLE: begin
				copy_d  = 1'b1;
				armed_d = 1'b1;
			end
			KIND_DISABLE, KIND_SINGLE_A, KIND_SINGLE_B, KIND_DISARM, KIND_TANDEM,
			KIND_INDEP: armed_d = 1'b0;
			default: armed_d = armed_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			last_tick_q <= '0;
			valid_s1    <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				armed_q <= armed_d;
				if (fire_d) begin
					last_tick_q <= in_ent.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			ent_s1   <= in_ent;
			fire_s1  <= fire_d;
			copy_s1  <= copy_d;
			armed_s1 <= armed_d;
			step_s1  <= STEP_W'(el_sat) * STEP_W'(cfg.max_speed);
		end
	end

	always_comb begin
		slew_p = approach(cur_p_q, tgt_p_q, step_s1);
		slew_y = approach(cur_y_q, tgt_y_q, step_s1);
		tick_a = clamp20(CMD_W'(org_a_q) + CMD_W'(slew_p), -CMD_LIM, CMD_LIM);
		tick_b = clamp20(CMD_W'(org_b_q) + CMD_W'(slew_p), -CMD_LIM, CMD_LIM);
		pair_a = clamp20(CMD_W'(org_a_q) + CMD_W'(ent_s1.man_a), -CMD_LIM, CMD_LIM);
		pair_b = clamp20(CMD_W'(org_b_q) + CMD_W'(ent_s1.man_a), -CMD_LIM, CMD_LIM);
		here_a = clamp20(man_a_q, -ORG_LIM, ORG_LIM);
		here_b = clamp20(man_b_q, -ORG_LIM, ORG_LIM);
	end

	always_comb begin
		cur_p_d = cur_p_q;
		cur_y_d = cur_y_q;
		tgt_p_d = tgt_p_q;
		tgt_y_d = tgt_y_q;
		org_a_d = org_a_q;
		org_b_d = org_b_q;
		man_a_d = man_a_q;
		man_b_d = man_b_q;
		mode_d  = mode_q;
		att_a_d = att_a_q;
		att_b_d = att_b_q;
		res_d   = '0;
		case (ent_s1.kind)
			KIND_TICK: begin
				if (fire_s1) begin
					cur_p_d        = slew_p;
					cur_y_d        = slew_y;
					res_d.wa_valid = 1'b1;
					res_d.wb_valid = 1'b1;
					res_d.wa_angle = tick_a;
					res_d.wb_angle = tick_b;
				end
			end
			KIND_TARGET: begin
				tgt_p_d = ent_s1.tgt_p;
				tgt_y_d = ent_s1.tgt_y;
				if (copy_s1) begin
					cur_p_d = ent_s1.tgt_p;
					cur_y_d = ent_s1.tgt_y;
				end
			end
			KIND_ENABLE: begin
				cur_p_d = tgt_p_q;
				cur_y_d = tgt_y_q;
			end
			KIND_DISABLE: begin
				att_a_d = 1'b0;
				att_b_d = 1'b0;
				mode_d  = MODE_NONE;
			end
			KIND_SINGLE_A: begin
				att_b_d        = 1'b0;
				res_d.wa_valid = 1'b1;
				res_d.wa_angle = CMD_W'(ent_s1.man_a);
				mode_d         = MODE_A;
				man_a_d        = CMD_W'(ent_s1.man_a);
			end
			KIND_SINGLE_B: begin
				att_a_d        = 1'b0;
				res_d.wb_valid = 1'b1;
				res_d.wb_angle = CMD_W'(ent_s1.man_a);
				mode_d         = MODE_B;
				man_a_d        = CMD_W'(ent_s1.man_a);
			end
			KIND_TANDEM: begin
				res_d.wa_valid = 1'b1;
				res_d.wb_valid = 1'b1;
				res_d.wa_angle = pair_a;
				res_d.wb_angle = pair_b;
				mode_d         = MODE_PAIR;
				man_a_d        = pair_a;
				man_b_d        = pair_b;
			end
			KIND_INDEP: begin
				res_d.wa_valid = 1'b1;
				res_d.wb_valid = 1'b1;
				res_d.wa_angle = CMD_W'(ent_s1.man_a);
				res_d.wb_angle = CMD_W'(ent_s1.man_b);
				mode_d         = MODE_INDEP;
				man_a_d        = CMD_W'(ent_s1.man_a);
				man_b_d        = CMD_W'(ent_s1.man_b);
			end
			KIND_ORIGIN_HERE: begin
				org_a_d = here_a[ORG_W-1:0];
				org_b_d = here_b[ORG_W-1:0];
			end
			KIND_ORIGIN_LOAD: begin
				org_a_d = ent_s1.org_a;
				org_b_d = ent_s1.org_b;
			end
			default: mode_d = mode_q;
		endcase
		if (res_d.wa_valid) begin
			att_a_d = 1'b1;
		end
		if (res_d.wb_valid) begin
			att_b_d = 1'b1;
		end
		res_d.a_att  = att_a_d;
		res_d.b_att  = att_b_d;
		res_d.armed  = armed_s1;
		res_d.mode   = mode_d;
		res_d.last_a = man_a_d;
		res_d.last_b = man_b_d;
		res_d.org_a  = org_a_d;
		res_d.org_b  = org_b_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_p_q     <= '0;
			cur_y_q     <= '0;
			tgt_p_q     <= '0;
			tgt_y_q     <= '0;
			org_a_q     <= '0;
			org_b_q     <= '0;
			man_a_q     <= '0;
			man_b_q     <= '0;
			mode_q      <= MODE_NONE;
			att_a_q     <= 1'b0;
			att_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				cur_p_q <= cur_p_d;
				cur_y_q <= cur_y_d;
				tgt_p_q <= tgt_p_d;
				tgt_y_q <= tgt_y_d;
				org_a_q <= org_a_d;
				org_b_q <= org_b_d;
				man_a_q <= man_a_d;
				man_b_q <= man_b_d;
				mode_q  <= mode_d;
				att_a_q <= att_a_d;
				att_b_q <= att_b_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_q <= res_d;
		end
	end

	a_idle_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.wa_valid |-> out_q.wa_angle == '0)
		else $error("servo A angle is nonzero without a command");

	a_cmd_attaches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.wa_valid |-> out_q.a_att)
		else $error("servo A commanded but reported detached");

	a_single_a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.wa_valid && !out_q.wb_valid |->
		out_q.mode == MODE_A && !out_q.armed)
		else $error("lone servo A command outside single joint A drive");

endmodule
